// File: rtl/core/token_bucket_shaper_ecn_admission_defines.svh
// ----------------------------------------------------------------------------
// token bucket shaper assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_SHAPER_ECN_ADMISSION_DEFINES_SVH
`define TOKEN_BUCKET_SHAPER_ECN_ADMISSION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbs same-cycle check failed");

// next-cycle implication, disabled in reset
`define TBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbs next-cycle check failed");

`endif

// File: rtl/core/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// types, widths and reset values shared by the token bucket shaper
// ----------------------------------------------------------------------------
`default_nettype none

package tbs_pkg;

    localparam int LEN_W    = 17;
    localparam int TIME_W   = 48;
    localparam int BYTES_W  = 24;
    localparam int CREDIT_W = 32;
    localparam int MULT_W   = 32;
    localparam int COST_W   = LEN_W + MULT_W;
    localparam int TOKEN_W  = TIME_W + 5;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int RATE_SHIFT_DEF       = 15;
    localparam int MIN_PACKET_BYTES_DEF = 64;
    localparam int FIFO_DEPTH           = 4;

    localparam logic [BYTES_W-1:0]  MAX_QUEUE_RST = 24'd1048576;
    localparam logic [BYTES_W-1:0]  ECN_THR_RST   = 24'd30720;
    localparam logic [CREDIT_W-1:0] DEPTH_RST     = 32'd4000000;
    localparam logic [MULT_W-1:0]   MULT_RST      = 32'd278876;

    typedef enum logic [0:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_QUEUE = 2'd0,
        CFG_ECN_THR   = 2'd1,
        CFG_DEPTH     = 2'd2,
        CFG_MULT      = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTES_W-1:0]  max_queue;
        logic [BYTES_W-1:0]  ecn_thr;
        logic [CREDIT_W-1:0] depth;
    } t_back_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
        logic [COST_W-1:0] cost;
    } t_work;

    typedef struct packed {
        logic               accepted;
        logic               ecn_mark;
        logic               released;
        logic               throttled;
        logic [TIME_W-1:0]  wake_time;
        logic [BYTES_W-1:0] queued_bytes;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_fifo_ctl;

endpackage

`default_nettype wire

// File: rtl/core/token_bucket_shaper_ecn_admission.sv
// ----------------------------------------------------------------------------
// token_bucket_shaper_ecn_admission
// byte admission with ecn marking and a token bucket shaper for dequeues
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result, in order. The block takes one
// item per clock and returns one result per clock when the result side pops
// every cycle. An accepted item is first held in the front stage, where the
// 17 x 32 bit transmission-cost multiply is registered, then moves to the
// four-entry work queue, whose head passes through the combinational admission
// and bucket update into the four-entry result queue. Either side may stall
// on its own; the queues absorb the difference until they fill, at which
// point full rises. The user must write configuration registers through the
// plain write port only while no item is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module token_bucket_shaper_ecn_admission
    import tbs_pkg::*;
#(
    parameter int RATE_SHIFT       = RATE_SHIFT_DEF,
    parameter int MIN_PACKET_BYTES = MIN_PACKET_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_command,
    input  wire logic [LEN_W-1:0]     i_packet_length,
    input  wire logic [TIME_W-1:0]    i_now_ns,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      o_accepted,
    output logic                      o_ecn_mark,
    output logic                      o_released,
    output logic                      o_throttled,
    output logic [TIME_W-1:0]         o_wake_time_ns,
    output logic [BYTES_W-1:0]        o_queued_bytes
);

    logic [BYTES_W-1:0]  r_max_queue;
    logic [BYTES_W-1:0]  r_ecn_thr;
    logic [CREDIT_W-1:0] r_depth;
    logic [MULT_W-1:0]   r_mult;

    t_back_cfg back_cfg;
    t_work     front_work;
    t_work     mid_work;
    t_result   back_result;
    t_result   out_result;
    logic      mid_push;
    logic      mid_full;
    logic      mid_empty;
    logic      back_fire;
    logic      out_full;
    logic      out_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_queue <= MAX_QUEUE_RST;
            r_ecn_thr   <= ECN_THR_RST;
            r_depth     <= DEPTH_RST;
            r_mult      <= MULT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_MAX_QUEUE: r_max_queue <= i_cfg_wdata[BYTES_W-1:0];
                CFG_ECN_THR:   r_ecn_thr   <= i_cfg_wdata[BYTES_W-1:0];
                CFG_DEPTH:     r_depth     <= i_cfg_wdata[CREDIT_W-1:0];
                CFG_MULT:      r_mult      <= i_cfg_wdata[MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.max_queue = r_max_queue;
    assign back_cfg.ecn_thr   = r_ecn_thr;
    assign back_cfg.depth     = r_depth;

    tbs_front #(
        .RATE_SHIFT       (RATE_SHIFT),
        .MIN_PACKET_BYTES (MIN_PACKET_BYTES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_command         (i_command),
        .i_packet_length   (i_packet_length),
        .i_now_ns          (i_now_ns),
        .i_rate_multiplier (r_mult),
        .i_queue_full      (mid_full),
        .o_full            (full),
        .o_queue_push      (mid_push),
        .o_work            (front_work)
    );

    tbs_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (FIFO_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_work),
        .i_pop   (back_fire),
        .o_data  (mid_work),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    tbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (back_cfg),
        .i_work        (mid_work),
        .i_work_empty  (mid_empty),
        .i_result_full (out_full),
        .o_fire        (back_fire),
        .o_result      (back_result)
    );

    tbs_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (FIFO_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_fire),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_data  (out_result),
        .o_full  (out_full),
        .o_empty (out_empty)
    );

    assign empty          = out_empty;
    assign o_accepted     = out_result.accepted;
    assign o_ecn_mark     = out_result.ecn_mark;
    assign o_released     = out_result.released;
    assign o_throttled    = out_result.throttled;
    assign o_wake_time_ns = out_result.wake_time;
    assign o_queued_bytes = out_result.queued_bytes;

endmodule

`default_nettype wire

// File: rtl/core/tbs_fifo.sv
// ----------------------------------------------------------------------------
// tbs_fifo
// small register queue with occupancy count, head shown combinationally
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tbs_front.sv
// ----------------------------------------------------------------------------
// tbs_front
// accepts items, raises short lengths and registers the transmission cost
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_front
    import tbs_pkg::*;
#(
    parameter int RATE_SHIFT       = RATE_SHIFT_DEF,
    parameter int MIN_PACKET_BYTES = MIN_PACKET_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_command,
    input  wire logic [LEN_W-1:0]  i_packet_length,
    input  wire logic [TIME_W-1:0] i_now_ns,
    input  wire logic [MULT_W-1:0] i_rate_multiplier,
    input  wire logic              i_queue_full,
    output logic                   o_full,
    output logic                   o_queue_push,
    output t_work                  o_work
);

    logic              r_valid;
    t_work             r_work;
    t_work             n_work;
    logic [LEN_W-1:0]  len_clamped;
    logic [COST_W-1:0] product;
    logic              advance;

    assign advance = !r_valid || !i_queue_full;
    assign o_full  = !advance;
    assign o_queue_push = r_valid && !i_queue_full;
    assign o_work  = r_work;

    always_comb begin
        len_clamped = (i_packet_length < LEN_W'(MIN_PACKET_BYTES))
                    ? LEN_W'(MIN_PACKET_BYTES) : i_packet_length;
        product = {{MULT_W{1'b0}}, len_clamped} * {{LEN_W{1'b0}}, i_rate_multiplier};
        n_work.cmd  = t_cmd'(i_command);
        n_work.len  = len_clamped;
        n_work.now  = i_now_ns;
        n_work.cost = product >> RATE_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_push) begin
            r_work <= n_work;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tbs_back.sv
// ----------------------------------------------------------------------------
// tbs_back
// byte admission and token bucket update, one item per cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_back
    import tbs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_back_cfg i_cfg,
    input  wire t_work     i_work,
    input  wire logic      i_work_empty,
    input  wire logic      i_result_full,
    output logic           o_fire,
    output t_result        o_result
);

    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;

    logic [BYTES_W:0]         enq_sum;
    logic                     enq_fits;
    logic [BYTES_W-1:0]       len_ext;
    logic signed [TOKEN_W-1:0] depth_s;
    logic signed [TOKEN_W-1:0] elapsed;
    logic signed [TOKEN_W-1:0] clip1;
    logic signed [TOKEN_W-1:0] sum2;
    logic signed [TOKEN_W-1:0] clip2;
    logic signed [TOKEN_W-1:0] toks;
    logic [TOKEN_W-1:0]       wake_full;
    logic                     grant;

    // mid queue has an item and the result queue has room
    assign o_fire = !i_work_empty && !i_result_full;

    always_comb begin
        len_ext  = {{(BYTES_W - LEN_W){1'b0}}, i_work.len};
        enq_sum  = {1'b0, r_bytes} + {1'b0, len_ext};
        enq_fits = (enq_sum <= {1'b0, i_cfg.max_queue});

        depth_s = $signed({{(TOKEN_W - CREDIT_W){1'b0}}, i_cfg.depth});
        elapsed = $signed({{(TOKEN_W - TIME_W){1'b0}}, i_work.now})
                - $signed({{(TOKEN_W - TIME_W){1'b0}}, r_last});
        clip1 = (elapsed > depth_s) ? depth_s : elapsed;
        sum2  = clip1 + $signed({{(TOKEN_W - CREDIT_W){1'b0}}, r_credit});
        clip2 = (sum2 > depth_s) ? depth_s : sum2;
        toks  = clip2 - $signed({{(TOKEN_W - COST_W){1'b0}}, i_work.cost});
        grant = !toks[TOKEN_W-1];
        // now plus the deficit
        wake_full = {{(TOKEN_W - TIME_W){1'b0}}, i_work.now} - $unsigned(toks);
    end

    always_comb begin
        n_credit = r_credit;
        n_last   = r_last;
        n_bytes  = r_bytes;
        o_result = '0;
        case (i_work.cmd)
            CMD_ENQUEUE: begin
                if (enq_fits) begin
                    n_bytes           = enq_sum[BYTES_W-1:0];
                    o_result.accepted = 1'b1;
                    o_result.ecn_mark = (enq_sum > {1'b0, i_cfg.ecn_thr});
                end
            end
            CMD_DEQUEUE: begin
                if (grant) begin
                    n_credit          = toks[CREDIT_W-1:0];
                    n_last            = i_work.now;
                    n_bytes           = (len_ext > r_bytes) ? '0 : r_bytes - len_ext;
                    o_result.released = 1'b1;
                end else begin
                    o_result.throttled = 1'b1;
                    o_result.wake_time = (wake_full[TOKEN_W-1:TIME_W] != '0)
                                       ? '1 : wake_full[TIME_W-1:0];
                end
            end
            default: begin
            end
        endcase
        o_result.queued_bytes = n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_last   <= '0;
            r_bytes  <= '0;
        end else if (o_fire) begin
            r_credit <= n_credit;
            r_last   <= n_last;
            r_bytes  <= n_bytes;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tbs_checker.sv
// ----------------------------------------------------------------------------
// tbs_checker
// port-level checks on the result side of the shaper
// ----------------------------------------------------------------------------
`default_nettype none

`include "token_bucket_shaper_ecn_admission_defines.svh"

module tbs_checker
    import tbs_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic               o_accepted,
    input wire logic               o_ecn_mark,
    input wire logic               o_released,
    input wire logic               o_throttled,
    input wire logic [TIME_W-1:0]  o_wake_time_ns,
    input wire logic [BYTES_W-1:0] o_queued_bytes
);

    // a result is at most one of admit, release or throttle
    `TBS_ASSERT_NOW(a_one_outcome, i_clk, i_rst_n, !empty, $onehot0({o_accepted, o_released, o_throttled}))

    // marking only on an admitted packet
    `TBS_ASSERT_NOW(a_ecn_needs_accept, i_clk, i_rst_n, !empty && o_ecn_mark, o_accepted)

    // wake time only meaningful when throttled
    `TBS_ASSERT_NOW(a_wake_only_throttled, i_clk, i_rst_n, !empty && !o_throttled, o_wake_time_ns == '0)

    // an admitted packet leaves bytes in the queue
    `TBS_ASSERT_NOW(a_accept_counts, i_clk, i_rst_n, !empty && o_accepted, o_queued_bytes != '0)

    // a waiting result holds until transfer
    `TBS_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_queued_bytes))

endmodule

bind token_bucket_shaper_ecn_admission tbs_checker u_tbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_accepted     (o_accepted),
    .o_ecn_mark     (o_ecn_mark),
    .o_released     (o_released),
    .o_throttled    (o_throttled),
    .o_wake_time_ns (o_wake_time_ns),
    .o_queued_bytes (o_queued_bytes)
);

`default_nettype wire
